>>> rtl/core/pid_motor_speed_drive_defines.svh
// Assertion macros for the speed drive RTL.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef PID_MOTOR_SPEED_DRIVE_DEFINES_SVH
`define PID_MOTOR_SPEED_DRIVE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pid_motor_speed_drive: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pid_motor_speed_drive: next-cycle check failed");

`endif

>>> rtl/core/pmsd_pkg.sv
// Constants and register codes of the motor speed drive.
// No dependencies; used by pmsd_div and pid_motor_speed_drive.
package pmsd_pkg;

    localparam int unsigned SPEED_PER_COUNT = 3142;   // 0.04793689962 in Q16.16
    localparam int unsigned PWM_PERIOD      = 14399;
    localparam int unsigned DIV_NUM_W       = 49;     // |diff| << 16
    localparam int unsigned DIV_DEN_W       = 24;     // time step width
    localparam logic [31:0] SPEED_UNLINKED  = 32'hFFFF_0000;

    typedef enum logic [3:0] {
        CFG_REF_SPEED  = 4'd0,
        CFG_GAIN_P     = 4'd1,
        CFG_GAIN_I     = 4'd2,
        CFG_GAIN_D     = 4'd3,
        CFG_INT_LIMIT  = 4'd4,
        CFG_RADIUS     = 4'd5,
        CFG_INVERT     = 4'd6,
        CFG_DOUBLE_CMP = 4'd7
    } t_cfg_idx;

endpackage

>>> rtl/core/pmsd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pmsd_pkg for default widths.
module pmsd_div import pmsd_pkg::*; #(
    parameter int unsigned NUM_W = DIV_NUM_W,
    parameter int unsigned DEN_W = DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_sub;
    logic             w_ge;

    assign w_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_ge  = (w_sh >= {1'b0, r_den});
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            // shift the next quotient bit in as the dividend shifts out
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_sh[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule

>>> rtl/core/pid_motor_speed_drive.sv
// Wheel speed PID loop: encoder count in, H-bridge direction and PWM compare out.
// Depends on pmsd_pkg, pmsd_div and pid_motor_speed_drive_defines.svh.
//
// Usage:
//  - Input stream: one transfer per control period. tdata holds encoder_count
//    [31:0] and time_step [55:32]; tuser holds connected.
//  - Output stream: one transfer per input. tdata holds measured_speed [31:0],
//    drive_command [46:32], compare_value [61:47]; tuser holds bridge_in_a [0]
//    and bridge_in_b [1].
//  - Config: write i_cfg_wdata to register i_cfg_addr while the block is idle;
//    indexes past the register list are ignored.
//  - Timing: a connected sample runs the scale, speed and error steps, then
//    starts the derivative divider, waits for it, then adds the D term and clamps.
//    Of the seven passes through the shared 32x32 multiplier, those for error
//    times step and the P and I terms overlap the divider. A disconnected
//    sample's output is valid in the cycle after its input transfer. One
//    sample is in flight at a time; tready drops after each transfer and
//    returns in the cycle after the output transfer.
//  - Stall: the result holds on the output until the receiver takes it; no new
//    input is taken until then.
//  - Reset: synchronous, active low; clears the integral, the previous error
//    and the registers (integral limit to its maximum) and returns to idle.
`include "pid_motor_speed_drive_defines.svh"

module pid_motor_speed_drive import pmsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // encoder_count[31:0], time_step[55:32]
    input  logic        i_s_axis_tuser,   // connected
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // measured_speed[31:0], drive_command[46:32],
                                          // compare_value[61:47], zero[63:62]
    output logic [1:0]  o_m_axis_tuser,   // bridge_in_a[0], bridge_in_b[1]
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_P1, S_P2, S_SPD, S_EDT, S_INT, S_TP, S_TI,
        S_DWAIT, S_TD, S_DRV, S_OUT
    } t_state;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // signed Q16.16 product term from a magnitude product shifted down by 16
    function automatic logic signed [48:0] term_of(input logic [47:0] m, input logic neg);
        logic signed [48:0] t;
        t = $signed({1'b0, m});
        return neg ? -t : t;
    endfunction

    // configuration registers
    logic signed [31:0] r_ref_speed, r_gain_p, r_gain_i, r_gain_d;
    logic [30:0]        r_int_limit, r_radius;
    logic               r_invert, r_double_cmp;

    // sequencer and working registers
    t_state             r_state;
    logic [31:0]        r_cmag;        // |encoder_count|
    logic               r_cneg;
    logic [23:0]        r_dt;
    logic [26:0]        r_scale_hi;
    logic [47:0]        r_p1;
    logic [63:0]        r_prod;
    logic               r_msign;
    logic signed [31:0] r_err, r_integ;
    logic               r_dsign;
    logic signed [49:0] r_sum;
    logic signed [31:0] r_integral, r_prev_err;

    // output registers
    logic [31:0]        r_o_speed;
    logic [14:0]        r_o_drive, r_o_cmp;
    logic               r_o_a, r_o_b;

    // shared multiplier
    logic [31:0]        w_ma, w_mb;
    logic [63:0]        w_prod;

    // speed and error
    logic [59:0]        w_msum;
    logic [43:0]        w_m;
    logic [31:0]        w_m32, w_spd0, w_speed;
    logic signed [32:0] w_e33, w_diff;
    logic signed [31:0] w_err;
    logic [32:0]        w_dmag;

    // integral, derivative, drive
    logic signed [48:0] w_term, w_isum, w_lim;
    logic [31:0]        w_qc;
    logic signed [31:0] w_deriv;
    logic [49:0]        w_sabs;
    logic [33:0]        w_dint;
    logic [14:0]        w_dmag15, w_drive;

    // divider
    logic               w_div_start, w_div_busy;
    logic [DIV_NUM_W-1:0] w_quot;

    assign w_prod = w_ma * w_mb;
    assign w_term = term_of(r_prod[63:16], r_msign);

    // speed = |count| * scale / 2^32, scale split at bit 16
    assign w_msum = {1'b0, r_prod[58:0]} + {28'b0, r_p1[47:16]};
    assign w_m    = w_msum[59:16];
    assign w_m32  = (w_m > 44'h0_8000_0000) ? 32'h8000_0000 : w_m[31:0];
    always_comb begin
        if (r_cneg) begin
            w_spd0 = ~w_m32 + 32'd1;
        end else begin
            w_spd0 = w_m32[31] ? 32'h7FFF_FFFF : w_m32;
        end
        if (r_invert) begin
            w_speed = (w_spd0 == 32'h8000_0000) ? 32'h7FFF_FFFF : (~w_spd0 + 32'd1);
        end else begin
            w_speed = w_spd0;
        end
    end

    assign w_e33 = {r_ref_speed[31], r_ref_speed} - {w_speed[31], w_speed};
    assign w_err = (w_e33[32] != w_e33[31]) ?
                   (w_e33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_e33[31:0];
    // error difference from the registered error, in the cycle after the speed
    assign w_diff = {r_err[31], r_err} - {r_prev_err[31], r_prev_err};
    assign w_dmag = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);

    assign w_div_start = (r_state == S_EDT) && (r_dt != 24'd0);

    // integral update with clamp to +-limit
    assign w_isum = $signed({{17{r_integral[31]}}, r_integral}) + w_term;
    assign w_lim  = $signed({18'b0, r_int_limit});

    // derivative from quotient, saturated
    assign w_qc = (w_quot > DIV_NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : w_quot[31:0];
    always_comb begin
        if (r_dt == 24'd0) begin
            w_deriv = '0;
        end else if (r_dsign) begin
            w_deriv = $signed(~w_qc + 32'd1);
        end else begin
            w_deriv = w_qc[31] ? 32'sh7FFF_FFFF : $signed(w_qc);
        end
    end

    // drive: truncate toward zero, clamp to the PWM period
    assign w_sabs   = r_sum[49] ? 50'(-r_sum) : 50'(r_sum);
    assign w_dint   = w_sabs[49:16];
    assign w_dmag15 = (w_dint > 34'(PWM_PERIOD)) ? 15'(PWM_PERIOD) : w_dint[14:0];
    assign w_drive  = r_sum[49] ? (~w_dmag15 + 15'd1) : w_dmag15;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_SCALE: begin
                w_ma = 32'(SPEED_PER_COUNT);
                w_mb = {1'b0, r_radius};
            end
            S_P1: begin
                w_ma = r_cmag;
                w_mb = {16'b0, r_prod[15:0]};
            end
            S_P2: begin
                w_ma = r_cmag;
                w_mb = {5'b0, r_scale_hi};
            end
            S_EDT: begin
                w_ma = mag32(r_err);
                w_mb = {8'b0, r_dt};
            end
            S_INT: begin
                w_ma = mag32(r_gain_p);
                w_mb = mag32(r_err);
            end
            S_TP: begin
                w_ma = mag32(r_gain_i);
                w_mb = mag32(r_integ);
            end
            S_DWAIT: begin
                w_ma = mag32(r_gain_d);
                w_mb = mag32(w_deriv);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    pmsd_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_dmag, 16'b0}),
        .i_den   (r_dt),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_speed  <= '0;
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_int_limit  <= 31'h7FFF_FFFF;
            r_radius     <= '0;
            r_invert     <= 1'b0;
            r_double_cmp <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_REF_SPEED:  r_ref_speed  <= $signed(i_cfg_wdata);
                CFG_GAIN_P:     r_gain_p     <= $signed(i_cfg_wdata);
                CFG_GAIN_I:     r_gain_i     <= $signed(i_cfg_wdata);
                CFG_GAIN_D:     r_gain_d     <= $signed(i_cfg_wdata);
                CFG_INT_LIMIT:  r_int_limit  <= i_cfg_wdata[30:0];
                CFG_RADIUS:     r_radius     <= i_cfg_wdata[30:0];
                CFG_INVERT:     r_invert     <= i_cfg_wdata[0];
                CFG_DOUBLE_CMP: r_double_cmp <= i_cfg_wdata[0];
                default: ;      // drop writes past the register list
            endcase
        end
    end

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_integral <= '0;
            r_prev_err <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_cmag <= mag32(i_s_axis_tdata[31:0]);
                        r_cneg <= i_s_axis_tdata[31];
                        r_dt   <= i_s_axis_tdata[55:32];
                        if (i_s_axis_tuser) begin
                            r_state <= S_SCALE;
                        end else begin
                            // disconnected: brake, hold PID state
                            r_o_speed <= SPEED_UNLINKED;
                            r_o_drive <= '0;
                            r_o_cmp   <= '0;
                            r_o_a     <= 1'b0;
                            r_o_b     <= 1'b0;
                            r_state   <= S_OUT;
                        end
                    end
                end
                S_SCALE: r_state <= S_P1;
                S_P1: begin
                    r_scale_hi <= r_prod[42:16];
                    r_state    <= S_P2;
                end
                S_P2: begin
                    r_p1    <= r_prod[47:0];
                    r_state <= S_SPD;
                end
                S_SPD: begin
                    r_o_speed <= w_speed;
                    r_err     <= w_err;
                    r_state   <= S_EDT;
                end
                S_EDT: begin
                    // start error*dt and the derivative divide from the held error
                    r_dsign <= w_diff[32];
                    r_msign <= r_err[31];
                    r_state <= S_INT;
                end
                S_INT: begin
                    if (w_isum > w_lim) begin
                        r_integ <= $signed({1'b0, r_int_limit});
                    end else if (w_isum < -w_lim) begin
                        r_integ <= -$signed({1'b0, r_int_limit});
                    end else begin
                        r_integ <= w_isum[31:0];
                    end
                    r_msign <= r_gain_p[31] ^ r_err[31];
                    r_state <= S_TP;
                end
                S_TP: begin
                    r_sum   <= {w_term[48], w_term};
                    r_msign <= r_gain_i[31] ^ r_integ[31];
                    r_state <= S_TI;
                end
                S_TI: begin
                    r_sum   <= r_sum + {w_term[48], w_term};
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if ((r_dt == 24'd0) || !w_div_busy) begin
                        r_msign <= r_gain_d[31] ^ w_deriv[31];
                        r_state <= S_TD;
                    end
                end
                S_TD: begin
                    r_sum   <= r_sum + {w_term[48], w_term};
                    r_state <= S_DRV;
                end
                S_DRV: begin
                    r_o_drive  <= w_drive;
                    r_o_cmp    <= r_double_cmp ? {w_dmag15[13:0], 1'b0} : w_dmag15;
                    r_o_a      <= !r_sum[49] && (w_dmag15 != 15'd0);
                    r_o_b      <= r_sum[49] && (w_dmag15 != 15'd0);
                    r_integral <= r_integ;
                    r_prev_err <= r_err;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {2'b00, r_o_cmp, r_o_drive, r_o_speed};
    assign o_m_axis_tuser  = {r_o_b, r_o_a};

    `PMSD_ASSERT_IMP(a_bridge_excl, o_m_axis_tvalid, !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
    `PMSD_ASSERT_IMP(a_drive_has_cmp, o_m_axis_tvalid && (o_m_axis_tuser != 2'b00), o_m_axis_tdata[61:47] != 15'd0)
    `PMSD_ASSERT_NXT(a_busy_after_in, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `PMSD_ASSERT_NXT(a_hold_unlinked, i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser, $stable(r_integral) && $stable(r_prev_err))

endmodule
